// File: rtl/bcn_pkg.sv
// Shared types, format codes and constant-divide helpers for the BCn texture block decoder.
package bcn_pkg;

    // Values of the block_format register.
    localparam logic [2:0] FMT_BC1    = 3'd0;
    localparam logic [2:0] FMT_BC1_4C = 3'd1;
    localparam logic [2:0] FMT_BC2    = 3'd2;
    localparam logic [2:0] FMT_BC3    = 3'd3;
    localparam logic [2:0] FMT_BC4    = 3'd4;
    localparam logic [2:0] FMT_BC5    = 3'd5;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0] TEXEL_CLEAR  = 32'h0000_0000;
    localparam logic [3:0]  LAST_TEXEL   = 4'd15;

    // Three 8-bit channels, [2] red, [1] green, [0] blue.
    typedef logic [2:0][7:0] t_chan3;
    // Three channel sums before the divide by three.
    typedef logic [2:0][9:0] t_sum3;
    // Eight-entry alpha or single-channel ramp.
    typedef logic [7:0][7:0] t_ramp;
    // Four-entry colour palette, ARGB.
    typedef logic [3:0][31:0] t_pal;

    // Load enables of the palette pipeline stages.
    typedef struct packed {
        logic s2;
        logic s3;
    } t_pipe_en;

    // Rounded quotients by reciprocal multiplication; exact over the value ranges used here.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(683);
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(1639);
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(2341);
        return p[21:14];
    endfunction

endpackage

// File: rtl/bcn_if.sv
// Valid/ready channel interfaces for compressed blocks in and decoded texels out.
interface bcn_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_lo;
    logic [63:0] block_hi;

    modport source (output valid, output block_lo, output block_hi, input ready);
    modport sink   (input valid, input block_lo, input block_hi, output ready);
endinterface

interface bcn_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  texel_index;
    logic [31:0] texel_value;
    logic        last_texel;

    modport source (output valid, output texel_index, output texel_value, output last_texel,
                    input ready);
    modport sink   (input valid, input texel_index, input texel_value, input last_texel,
                    output ready);
endinterface

// File: rtl/bcn_ramp.sv
// Two-stage builder of one eight-entry alpha or single-channel ramp.
module bcn_ramp (
    input  logic             i_clk,
    input  bcn_pkg::t_pipe_en i_en,
    input  logic [15:0]      i_ends,
    output bcn_pkg::t_ramp   o_ramp
);

    logic [10:0] n_s7 [2:7];
    logic [10:0] n_s5 [2:5];
    logic [10:0] r_s7 [2:7];
    logic [10:0] r_s5 [2:5];
    logic [7:0]  r_a0;
    logic [7:0]  r_a1;
    logic        r_gt;
    bcn_pkg::t_ramp n_ramp;
    bcn_pkg::t_ramp r_ramp;

    // Weighted endpoint sums with their rounding offsets.
    always_comb begin
        for (int k = 2; k < 8; k++) begin
            n_s7[k] = 11'(8 - k) * {3'b000, i_ends[7:0]} + 11'(k - 1) * {3'b000, i_ends[15:8]}
                      + 11'd3;
        end
        for (int k = 2; k < 6; k++) begin
            n_s5[k] = 11'(6 - k) * {3'b000, i_ends[7:0]} + 11'(k - 1) * {3'b000, i_ends[15:8]}
                      + 11'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s7 <= n_s7;
            r_s5 <= n_s5;
            r_a0 <= i_ends[7:0];
            r_a1 <= i_ends[15:8];
            r_gt <= (i_ends[7:0] > i_ends[15:8]);
        end
    end

    always_comb begin
        n_ramp[0] = r_a0;
        n_ramp[1] = r_a1;
        if (r_gt) begin
            for (int k = 2; k < 8; k++) begin
                n_ramp[k] = bcn_pkg::div7(r_s7[k]);
            end
        end else begin
            for (int k = 2; k < 6; k++) begin
                n_ramp[k] = bcn_pkg::div5(r_s5[k]);
            end
            n_ramp[6] = 8'h00;
            n_ramp[7] = 8'hFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_ramp <= n_ramp;
        end
    end

    assign o_ramp = r_ramp;

endmodule

// File: rtl/bcn_texture_block_decoder.sv
// Top level of the BC1 to BC5 texture block decoder: palette pipeline and texel serializer.
//
//  Channel   Dir  Handshake          Payload
//  i_blk     in   valid / ready      block_lo[63:0], block_hi[63:0]
//  o_tex     out  valid / ready      texel_index[3:0], texel_value[31:0], last_texel
//  cfg       in   i_cfg_we           i_cfg_wdata[2:0] -> block_format
//
// A block passes three palette stages and then sits in the serializer, which hands
// sixteen texels to the output register, one per cycle while the output accepts them;
// it loads the next block as the last texel goes out. The first texel passes stages
// 1 to 3, the serializer and the output register. Reset clears all valid bits and
// sets block_format to BC1. A stalled output holds its texel; backpressure stops the
// serializer and then the pipeline stages, each of which still fills its empty slot.
module bcn_texture_block_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_wdata,
    bcn_in_if.sink         i_blk,
    bcn_out_if.source      o_tex
);

    // Configuration register.
    logic [2:0] r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= bcn_pkg::FMT_BC1;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // Pipeline control. Each stage loads when it is empty or when its content moves on.
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [3:0] r_s4_cnt;
    logic r_ov;
    logic en1, en2, en3, out_ready, emit, ser_load;
    bcn_pkg::t_pipe_en pen;

    assign out_ready = !r_ov || o_tex.ready;
    assign emit      = r_s4_v && out_ready;
    assign ser_load  = !r_s4_v || (emit && (r_s4_cnt == bcn_pkg::LAST_TEXEL));
    assign en3       = !r_s3_v || ser_load;
    assign en2       = !r_s2_v || en3;
    assign en1       = !r_s1_v || en2;
    assign pen       = '{s2: en2, s3: en3};
    assign i_blk.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_s4_cnt <= 4'd0;
            r_ov     <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= i_blk.valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (ser_load) begin
                r_s4_v   <= r_s3_v;
                r_s4_cnt <= 4'd0;
            end else if (emit) begin
                r_s4_cnt <= r_s4_cnt + 4'd1;
            end
            if (out_ready) begin
                r_ov <= r_s4_v;
            end
        end
    end

    // Stage 1: captured block and the format it decodes under.
    logic [63:0] r_s1_lo, r_s1_hi;
    logic [2:0]  r_s1_fmt;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_lo  <= i_blk.block_lo;
            r_s1_hi  <= i_blk.block_hi;
            r_s1_fmt <= r_fmt;
        end
    end

    // Colour endpoints widened from 565 by bit replication, and the middle-colour sums.
    logic [31:0]     cword;
    logic [15:0]     n0, n1;
    bcn_pkg::t_chan3 e0, e1, n_half;
    bcn_pkg::t_sum3  n_sa, n_sb;
    logic [8:0]      hsum;
    logic            n_punch;

    always_comb begin
        cword = ((r_s1_fmt == bcn_pkg::FMT_BC1) || (r_s1_fmt == bcn_pkg::FMT_BC1_4C)) ?
                r_s1_lo[31:0] : r_s1_hi[31:0];
        n0 = cword[15:0];
        n1 = cword[31:16];
        e0 = {{n0[15:11], n0[15:13]}, {n0[10:5], n0[10:9]}, {n0[4:0], n0[4:2]}};
        e1 = {{n1[15:11], n1[15:13]}, {n1[10:5], n1[10:9]}, {n1[4:0], n1[4:2]}};
        // Three-colour mode with transparent black exists only for BC1.
        n_punch = (r_s1_fmt == bcn_pkg::FMT_BC1) && (n0 <= n1);
        hsum = 9'd0;
        for (int ch = 0; ch < 3; ch++) begin
            n_sa[ch]   = {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]} + 10'd1;
            n_sb[ch]   = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0} + 10'd1;
            hsum       = {1'b0, e0[ch]} + {1'b0, e1[ch]};
            n_half[ch] = hsum[8:1];
        end
    end

    // Stage 2.
    logic [63:0]     r_s2_lo, r_s2_hi;
    logic [2:0]      r_s2_fmt;
    bcn_pkg::t_chan3 r_s2_e0, r_s2_e1, r_s2_half;
    bcn_pkg::t_sum3  r_s2_sa, r_s2_sb;
    logic            r_s2_punch;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_lo    <= r_s1_lo;
            r_s2_hi    <= r_s1_hi;
            r_s2_fmt   <= r_s1_fmt;
            r_s2_e0    <= e0;
            r_s2_e1    <= e1;
            r_s2_half  <= n_half;
            r_s2_sa    <= n_sa;
            r_s2_sb    <= n_sb;
            r_s2_punch <= n_punch;
        end
    end

    // Four-entry palette.
    bcn_pkg::t_pal   n_pal;
    bcn_pkg::t_chan3 c2, c3;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            c2[ch] = bcn_pkg::div3(r_s2_sa[ch]);
            c3[ch] = bcn_pkg::div3(r_s2_sb[ch]);
        end
        n_pal[0] = {bcn_pkg::ALPHA_OPAQUE, r_s2_e0};
        n_pal[1] = {bcn_pkg::ALPHA_OPAQUE, r_s2_e1};
        if (r_s2_punch) begin
            n_pal[2] = {bcn_pkg::ALPHA_OPAQUE, r_s2_half};
            n_pal[3] = bcn_pkg::TEXEL_CLEAR;
        end else begin
            n_pal[2] = {bcn_pkg::ALPHA_OPAQUE, c2};
            n_pal[3] = {bcn_pkg::ALPHA_OPAQUE, c3};
        end
    end

    // Ramps from the first and second words; each builder spans stages 2 and 3.
    bcn_pkg::t_ramp ramp_lo, ramp_hi;

    bcn_ramp u_ramp_lo (
        .i_clk  (i_clk),
        .i_en   (pen),
        .i_ends (r_s1_lo[15:0]),
        .o_ramp (ramp_lo)
    );

    bcn_ramp u_ramp_hi (
        .i_clk  (i_clk),
        .i_en   (pen),
        .i_ends (r_s1_hi[15:0]),
        .o_ramp (ramp_hi)
    );

    // Stage 3.
    logic [63:0]   r_s3_lo, r_s3_hi;
    logic [2:0]    r_s3_fmt;
    bcn_pkg::t_pal r_s3_pal;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_lo  <= r_s2_lo;
            r_s3_hi  <= r_s2_hi;
            r_s3_fmt <= r_s2_fmt;
            r_s3_pal <= n_pal;
        end
    end

    // Serializer: holds one decoded block while its sixteen texels go out.
    logic [63:0]    r_s4_lo, r_s4_hi;
    logic [2:0]     r_s4_fmt;
    bcn_pkg::t_pal  r_s4_pal;
    bcn_pkg::t_ramp r_s4_rlo, r_s4_rhi;

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_s4_lo  <= r_s3_lo;
            r_s4_hi  <= r_s3_hi;
            r_s4_fmt <= r_s3_fmt;
            r_s4_pal <= r_s3_pal;
            r_s4_rlo <= ramp_lo;
            r_s4_rhi <= ramp_hi;
        end
    end

    // Per-texel index lookup and channel assembly.
    logic [31:0] ccode_word, col, n_texel;
    logic [1:0]  ccode;
    logic [5:0]  aoff;
    logic [2:0]  acode, hcode;
    logic [3:0]  a4;

    always_comb begin
        ccode_word = ((r_s4_fmt == bcn_pkg::FMT_BC1) || (r_s4_fmt == bcn_pkg::FMT_BC1_4C)) ?
                     r_s4_lo[63:32] : r_s4_hi[63:32];
        ccode = ccode_word[{r_s4_cnt, 1'b0} +: 2];
        col   = r_s4_pal[ccode];
        // Three-bit codes start after the two 8-bit endpoints.
        aoff  = 6'd16 + {1'b0, r_s4_cnt, 1'b0} + {2'b00, r_s4_cnt};
        acode = r_s4_lo[aoff +: 3];
        hcode = r_s4_hi[aoff +: 3];
        a4    = r_s4_lo[{r_s4_cnt, 2'b00} +: 4];
        case (r_s4_fmt)
            bcn_pkg::FMT_BC1,
            bcn_pkg::FMT_BC1_4C: n_texel = col;
            bcn_pkg::FMT_BC2:    n_texel = {a4, a4, col[23:0]};
            bcn_pkg::FMT_BC3:    n_texel = {r_s4_rlo[acode], col[23:0]};
            bcn_pkg::FMT_BC4:    n_texel = {24'h000000, r_s4_rlo[acode]};
            bcn_pkg::FMT_BC5:    n_texel = {16'h0000, r_s4_rhi[hcode], r_s4_rlo[acode]};
            default:             n_texel = bcn_pkg::TEXEL_CLEAR;
        endcase
    end

    // Output register.
    logic [3:0]  r_oidx;
    logic [31:0] r_oval;
    logic        r_olast;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oidx  <= r_s4_cnt;
            r_oval  <= n_texel;
            r_olast <= (r_s4_cnt == bcn_pkg::LAST_TEXEL);
        end
    end

    assign o_tex.valid       = r_ov;
    assign o_tex.texel_index = r_oidx;
    assign o_tex.texel_value = r_oval;
    assign o_tex.last_texel  = r_olast;

`ifndef SYNTHESIS
    // The end marker sits exactly on the sixteenth texel.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tex.valid |-> (o_tex.last_texel == (o_tex.texel_index == bcn_pkg::LAST_TEXEL)))
        else $error("last_texel does not match texel_index");

    // Within a block the texel index advances by one per transaction.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tex.valid && o_tex.ready && !o_tex.last_texel) |=>
        (o_tex.valid && (o_tex.texel_index == 4'($past(o_tex.texel_index) + 4'd1))))
        else $error("texel index skipped or repeated");

    // A stalled serializer keeps its position.
    a_ser_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_v && !emit) |=> (r_s4_v && $stable(r_s4_cnt)))
        else $error("serializer moved while stalled");
`endif

endmodule

// File: bench/bcn_texture_block_decoder_test.sv
// Self-checking testbench for the BC1 to BC5 texture block decoder.
`timescale 1ns / 1ps

module bcn_texture_block_decoder_test;

    // The two format codes that the decoder does not use. They must still produce
    // sixteen texels, all of them zero.
    localparam logic [2:0] FMT_SPARE_6 = 3'd6;
    localparam logic [2:0] FMT_SPARE_7 = 3'd7;

    // Index patterns that walk through every code of a block. The two-bit pattern
    // gives codes 0, 1, 2, 3 across each row. The three-bit pattern gives codes 0 to 7
    // and then 0 to 7 again.
    localparam logic [31:0] EVERY_COLOUR_CODE = 32'hE4E4_E4E4;
    localparam logic [47:0] EVERY_RAMP_CODE   = 48'hFAC688_FAC688;

    // The receiver holds off for this many cycles during the backpressure test.
    localparam int OUTPUT_HOLD_CYCLES = 300;

    // The slowest correct run is about 450 blocks long, and this limit is several times
    // the time that it takes.
    localparam longint unsigned RUN_LIMIT_NS = 64'd12_000_000;

    typedef logic [3:0][31:0] t_palette;
    typedef logic [7:0][7:0]  t_ramp;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] value;
        logic        last;
    } t_texel;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_wdata;

    bcn_in_if  blk ();
    bcn_out_if tex ();

    bcn_texture_block_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_blk       (blk),
        .o_tex       (tex)
    );

    // This is the bench's own copy of block_format. It starts at the reset value and
    // follows every register write.
    logic [2:0] shadow_format = bcn_pkg::FMT_BC1;

    // These are the decoded texels that the bench expects, oldest first.
    t_texel pending_texels[$];

    int mismatch_count = 0;

    // These flags control idling. The tests change them between phases.
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    bit hold_req  = 1'b0;

    always #10 i_clk = ~i_clk;

    // Prints one line for each mismatch and counts every one of them.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns  MISMATCH: %s", $time, what);
    endtask

    //------------------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------------------

    // Builds the four-entry ARGB palette from the two 565 endpoints in w[31:0].
    // Each endpoint is widened to 8 bits per channel by repeating its top bits.
    // With punch set and colour0 <= colour1, the palette is the three-colour set:
    // the truncated mean of the endpoints, then transparent black.
    function automatic t_palette colour_palette(input logic [63:0] w, input bit punch);
        logic [15:0] e0;
        logic [15:0] e1;
        int unsigned c0 [3];
        int unsigned c1 [3];
        t_palette pal;
        e0 = w[15:0];
        e1 = w[31:16];
        c0[2] = {e0[15:11], e0[15:13]};
        c0[1] = {e0[10:5], e0[10:9]};
        c0[0] = {e0[4:0], e0[4:2]};
        c1[2] = {e1[15:11], e1[15:13]};
        c1[1] = {e1[10:5], e1[10:9]};
        c1[0] = {e1[4:0], e1[4:2]};
        pal = '0;
        pal[0][31:24] = bcn_pkg::ALPHA_OPAQUE;
        pal[1][31:24] = bcn_pkg::ALPHA_OPAQUE;
        pal[2][31:24] = bcn_pkg::ALPHA_OPAQUE;
        for (int k = 0; k < 3; k++) begin
            pal[0][8*k +: 8] = c0[k][7:0];
            pal[1][8*k +: 8] = c1[k][7:0];
            if (!punch || e0 > e1) begin
                pal[2][8*k +: 8] = 8'((2 * c0[k] + c1[k] + 1) / 3);
                pal[3][8*k +: 8] = 8'((2 * c1[k] + c0[k] + 1) / 3);
            end else begin
                pal[2][8*k +: 8] = 8'((c0[k] + c1[k]) / 2);
            end
        end
        if (!punch || e0 > e1) begin
            pal[3][31:24] = bcn_pkg::ALPHA_OPAQUE;
        end
        return pal;
    endfunction

    // Builds the eight-entry ramp from the two 8-bit endpoints in w[15:0]. When the
    // first endpoint is larger, the ramp holds six interpolated steps. Otherwise it
    // holds four steps, then 0, then 255.
    function automatic t_ramp value_ramp(input logic [63:0] w);
        int unsigned a0;
        int unsigned a1;
        t_ramp r;
        a0 = w[7:0];
        a1 = w[15:8];
        r[0] = w[7:0];
        r[1] = w[15:8];
        if (a0 > a1) begin
            for (int k = 2; k < 8; k++) begin
                r[k] = 8'(((8 - k) * a0 + (k - 1) * a1 + 3) / 7);
            end
        end else begin
            for (int k = 2; k < 6; k++) begin
                r[k] = 8'(((6 - k) * a0 + (k - 1) * a1 + 2) / 5);
            end
            r[6] = 8'h00;
            r[7] = 8'hFF;
        end
        return r;
    endfunction

    // Decodes one accepted block in the current format. It queues the sixteen texels
    // that the decoder must produce, in row-major order.
    function automatic void decode_block(input logic [63:0] lo, input logic [63:0] hi);
        t_palette pal;
        t_ramp ramp_lo;
        t_ramp ramp_hi;
        logic [3:0] a4;
        logic [31:0] v;
        t_texel item;
        pal = '0;
        ramp_lo = '0;
        ramp_hi = '0;
        case (shadow_format)
            bcn_pkg::FMT_BC1:    pal = colour_palette(lo, 1'b1);
            bcn_pkg::FMT_BC1_4C: pal = colour_palette(lo, 1'b0);
            bcn_pkg::FMT_BC2:    pal = colour_palette(hi, 1'b0);
            bcn_pkg::FMT_BC3: begin
                pal = colour_palette(hi, 1'b0);
                ramp_lo = value_ramp(lo);
            end
            bcn_pkg::FMT_BC4:    ramp_lo = value_ramp(lo);
            bcn_pkg::FMT_BC5: begin
                ramp_lo = value_ramp(lo);
                ramp_hi = value_ramp(hi);
            end
            default: ;
        endcase
        for (int t = 0; t < 16; t++) begin
            case (shadow_format)
                bcn_pkg::FMT_BC1, bcn_pkg::FMT_BC1_4C: v = pal[lo[32 + 2*t +: 2]];
                bcn_pkg::FMT_BC2: begin
                    // The explicit 4-bit alpha is widened by repeating its nibble.
                    a4 = lo[4*t +: 4];
                    v = {a4, a4, pal[hi[32 + 2*t +: 2]][23:0]};
                end
                bcn_pkg::FMT_BC3: begin
                    v = {ramp_lo[lo[16 + 3*t +: 3]], pal[hi[32 + 2*t +: 2]][23:0]};
                end
                bcn_pkg::FMT_BC4: v = {24'h0, ramp_lo[lo[16 + 3*t +: 3]]};
                bcn_pkg::FMT_BC5: begin
                    v = {16'h0, ramp_hi[hi[16 + 3*t +: 3]], ramp_lo[lo[16 + 3*t +: 3]]};
                end
                default: v = bcn_pkg::TEXEL_CLEAR;
            endcase
            item.index = 4'(t);
            item.value = v;
            item.last  = (4'(t) == bcn_pkg::LAST_TEXEL);
            pending_texels.push_back(item);
        end
    endfunction

    //------------------------------------------------------------------------------
    // Output side: receiver stalls and the texel checker
    //------------------------------------------------------------------------------

    // Ready changes only at the falling edge, and only once in each step. A hold
    // request takes priority: the receiver then stays off for a long stretch that this
    // process counts itself. Otherwise, while stalls are enabled, ready drops in
    // random bursts.
    initial begin : output_ready_driver
        int burst;
        tex.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                tex.ready <= 1'b0;
                repeat (OUTPUT_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 13);
                tex.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                tex.ready <= 1'b1;
            end
        end
    end

    // Each texel transaction is checked against the oldest expected texel, one field
    // at a time. A texel that arrives while nothing is expected is also a mismatch.
    always @(posedge i_clk) begin : texel_checker
        t_texel want;
        if (i_rst_n && tex.valid && tex.ready) begin
            if (pending_texels.size() == 0) begin
                report_mismatch($sformatf("texel %0d value %08h arrived with nothing expected",
                                          tex.texel_index, tex.texel_value));
            end else begin
                want = pending_texels.pop_front();
                if (tex.texel_index !== want.index) begin
                    report_mismatch($sformatf("texel_index %0d, expected %0d",
                                              tex.texel_index, want.index));
                end
                if (tex.texel_value !== want.value) begin
                    report_mismatch($sformatf("texel %0d value %08h, expected %08h (format %0d)",
                                              want.index, tex.texel_value, want.value,
                                              shadow_format));
                end
                if (tex.last_texel !== want.last) begin
                    report_mismatch($sformatf("texel %0d last_texel %0b, expected %0b",
                                              want.index, tex.last_texel, want.last));
                end
            end
        end
    end

    //------------------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------------------

    // Offers one block and returns at the falling edge after its transaction. While
    // gaps are enabled, valid sometimes drops first for a random burst. Otherwise valid
    // stays high from one block to the next.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            blk.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        blk.valid    <= 1'b1;
        blk.block_lo <= lo;
        blk.block_hi <= hi;
        @(posedge i_clk);
        while (!blk.ready) @(posedge i_clk);
        decode_block(lo, hi);
        @(negedge i_clk);
    endtask

    // Stops offering blocks and waits until every expected texel has arrived.
    task automatic wait_drained();
        blk.valid <= 1'b0;
        while (pending_texels.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Changes block_format only while the decoder is empty.
    task automatic set_format(input logic [2:0] fmt);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_format = fmt;
    endtask

    // Random colour words. These often force equal endpoints or extreme endpoints, so
    // that both palette modes and their edge case are reached.
    function automatic logic [63:0] shape_colour(input logic [63:0] w);
        case ($urandom_range(0, 7))
            0: w[31:16] = w[15:0];
            1: w[15:0]  = 16'h0000;
            2: w[31:16] = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // Random ramp words. These often force equal endpoints or full-range endpoints
    // in either order.
    function automatic logic [63:0] shape_ramp(input logic [63:0] w);
        case ($urandom_range(0, 7))
            0: w[15:8] = w[7:0];
            1: w[15:0] = 16'h00FF;
            2: w[15:0] = 16'hFF00;
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_block(input logic [2:0] fmt, output logic [63:0] lo,
                                output logic [63:0] hi);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        case (fmt)
            bcn_pkg::FMT_BC1, bcn_pkg::FMT_BC1_4C: lo = shape_colour(lo);
            bcn_pkg::FMT_BC2: hi = shape_colour(hi);
            bcn_pkg::FMT_BC3: begin
                lo = shape_ramp(lo);
                hi = shape_colour(hi);
            end
            bcn_pkg::FMT_BC4: lo = shape_ramp(lo);
            bcn_pkg::FMT_BC5: begin
                lo = shape_ramp(lo);
                hi = shape_ramp(hi);
            end
            default: ;
        endcase
    endtask

    //------------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------------

    // No register write comes before this test, so these blocks decode in the reset
    // format, BC1. The blocks cover these cases:
    // - equal black endpoints, which select the three-colour mode;
    // - equal white endpoints where every code is 3, which gives transparent black;
    // - colour0 > colour1, which gives four colours;
    // - colour0 < colour1, where codes 0 to 3 cover the three-colour palette.
    task automatic test_bc1_after_reset();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block({EVERY_COLOUR_CODE, 16'h001F, 16'hF800}, 64'h0);
        send_block({EVERY_COLOUR_CODE, 16'hF800, 16'h07E0}, 64'h0);
    endtask

    // In four-colour-only mode, endpoints that are equal or in increasing order must
    // still give interpolated colours, not the three-colour set.
    task automatic test_four_colour_only();
        set_format(bcn_pkg::FMT_BC1_4C);
        send_block({EVERY_COLOUR_CODE, 16'h1234, 16'h1234}, '1);
        send_block({~EVERY_COLOUR_CODE, 16'hFFFF, 16'h0000}, '1);
    endtask

    // BC2 takes its explicit alpha from the low word and its colour from the high word.
    task automatic test_explicit_alpha();
        set_format(bcn_pkg::FMT_BC2);
        send_block(64'h0123_4567_89AB_CDEF, {EVERY_COLOUR_CODE, 16'h07E0, 16'hF81F});
        send_block('1, '1);
        send_block(64'h0, 64'h0);
    endtask

    // BC3 uses the alpha ramp in both of its forms: the eight-step form, the six-step
    // form, and equal endpoints, which select the six-step form.
    task automatic test_ramp_alpha();
        set_format(bcn_pkg::FMT_BC3);
        send_block({EVERY_RAMP_CODE, 8'h10, 8'hF0}, {EVERY_COLOUR_CODE, 16'h001F, 16'hFFE0});
        send_block({EVERY_RAMP_CODE, 8'hF0, 8'h10}, {EVERY_COLOUR_CODE, 16'hFFFF, 16'h0000});
        send_block({EVERY_RAMP_CODE, 8'h80, 8'h80}, {EVERY_COLOUR_CODE, 16'h0000, 16'h0000});
    endtask

    // BC4 puts a single channel in the low byte of each texel, and BC5 puts two
    // channels in the low two bytes.
    task automatic test_channel_formats();
        set_format(bcn_pkg::FMT_BC4);
        send_block({EVERY_RAMP_CODE, 8'h00, 8'hFF}, 64'h0);
        send_block({EVERY_RAMP_CODE, 8'hFF, 8'h00}, 64'h0);
        send_block('1, 64'h0);
        set_format(bcn_pkg::FMT_BC5);
        send_block({EVERY_RAMP_CODE, 8'h20, 8'hE0}, {EVERY_RAMP_CODE, 8'hE0, 8'h20});
        send_block({EVERY_RAMP_CODE, 8'hE0, 8'h20}, {EVERY_RAMP_CODE, 8'h20, 8'hE0});
    endtask

    // The two unused codes must still give sixteen texels with the usual index and
    // last marker, each with a value of zero.
    task automatic test_unused_formats();
        set_format(FMT_SPARE_6);
        send_block('1, '1);
        set_format(FMT_SPARE_7);
        send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // This test runs random blocks through every format code, the extremes among them.
    // Each phase chooses its own idling at random, so a phase may have no idling at all.
    task automatic test_random_formats();
        logic [2:0] order [12] = '{bcn_pkg::FMT_BC5, bcn_pkg::FMT_BC1, bcn_pkg::FMT_BC3,
                                   FMT_SPARE_7, bcn_pkg::FMT_BC2, bcn_pkg::FMT_BC4,
                                   bcn_pkg::FMT_BC1_4C, FMT_SPARE_6, bcn_pkg::FMT_BC3,
                                   bcn_pkg::FMT_BC1, bcn_pkg::FMT_BC5, bcn_pkg::FMT_BC2};
        logic [63:0] lo;
        logic [63:0] hi;
        for (int p = 0; p < 12; p++) begin
            set_format(order[p]);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            repeat (28) begin
                random_block(order[p], lo, hi);
                send_block(lo, hi);
            end
        end
    endtask

    // In this test the receiver holds off for a long stretch while blocks keep coming,
    // so that every stage fills and the input stalls. The sender then pauses until the
    // decoder has drained completely, and after that it resumes.
    task automatic test_output_hold();
        logic [63:0] lo;
        logic [63:0] hi;
        set_format(bcn_pkg::FMT_BC3);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_req  = 1'b1;
        repeat (14) begin
            random_block(bcn_pkg::FMT_BC3, lo, hi);
            send_block(lo, hi);
        end
        wait_drained();
        stalls_on = 1'b1;
        repeat (6) begin
            random_block(bcn_pkg::FMT_BC3, lo, hi);
            send_block(lo, hi);
        end
    endtask

    // The final stretch runs back to back in both directions, at the full rate of one
    // texel every cycle.
    task automatic test_steady_tail();
        logic [63:0] lo;
        logic [63:0] hi;
        set_format(bcn_pkg::FMT_BC1);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (40) begin
            random_block(bcn_pkg::FMT_BC1, lo, hi);
            send_block(lo, hi);
        end
    endtask

    // This is the main sequence. Reset is applied once. The directed tests come next,
    // then the random phases and the pressure test, and the steady stretch comes last.
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = bcn_pkg::FMT_BC1;
        blk.valid    = 1'b0;
        blk.block_lo = '0;
        blk.block_hi = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_bc1_after_reset();
        test_four_colour_only();
        test_explicit_alpha();
        test_ramp_alpha();
        test_channel_formats();
        test_unused_formats();
        test_random_formats();
        test_output_hold();
        test_steady_tail();

        // Drain the decoder, then watch for stray texels a little longer.
        wait_drained();
        repeat (30) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // This watchdog ends the run if the decoder hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
